[design/ssi_pkg.sv]
package ssi_pkg;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    localparam logic REG_DISP_W = 1'b0;
    localparam logic REG_DISP_H = 1'b1;

    localparam logic [15:0] DISP_W_RESET = 16'd640;
    localparam logic [15:0] DISP_H_RESET = 16'd480;

    typedef struct packed {
        logic [14:0] x;
        logic [14:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } t_rect;

    typedef struct packed {
        logic [14:0] pos;
        logic [15:0] size;
    } t_axis;

    typedef struct packed {
        logic        clip_enable;
        t_rect       rect;
        logic [1:0]  error_code;
    } t_result;

    function automatic t_axis fold_axis(
        logic [14:0]        pos,
        logic [15:0]        size,
        logic signed [15:0] ipos,
        logic [15:0]        isize
    );
        logic signed [17:0] p;
        logic signed [17:0] ip;
        logic signed [17:0] lo;
        logic signed [17:0] hi_t;
        logic signed [17:0] hi_i;
        logic signed [17:0] hi;
        logic signed [17:0] diff;
        t_axis              res;
        p    = signed'({3'b000, pos});
        ip   = signed'({{2{ipos[15]}}, ipos});
        lo   = (ip > p) ? ip : p;
        hi_t = p + signed'({2'b00, size});
        hi_i = ip + signed'({2'b00, isize});
        hi   = (hi_i < hi_t) ? hi_i : hi_t;
        diff = hi - lo;
        res.pos  = lo[14:0];
        res.size = (hi > lo) ? diff[15:0] : 16'd0;
        return res;
    endfunction

endpackage

[design/ssi_req_if.sv]
interface ssi_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [15:0]        rect_w;
    logic [15:0]        rect_h;

    modport source (
        output valid, req_type, rect_x, rect_y, rect_w, rect_h,
        input  ready
    );
    modport sink (
        input  valid, req_type, rect_x, rect_y, rect_w, rect_h,
        output ready
    );
    modport monitor (
        input valid, ready, req_type, rect_x, rect_y, rect_w, rect_h
    );
endinterface

[design/ssi_rsp_if.sv]
interface ssi_rsp_if;
    logic        valid;
    logic        ready;
    logic        clip_enable;
    logic [14:0] clip_x;
    logic [14:0] clip_y;
    logic [15:0] clip_w;
    logic [15:0] clip_h;
    logic [1:0]  error_code;

    modport source (
        output valid, clip_enable, clip_x, clip_y, clip_w, clip_h, error_code,
        input  ready
    );
    modport sink (
        input  valid, clip_enable, clip_x, clip_y, clip_w, clip_h, error_code,
        output ready
    );
    modport monitor (
        input valid, ready, clip_enable, clip_x, clip_y, clip_w, clip_h, error_code
    );
endinterface

[design/scissor_stack_intersect_unit.sv]
// Results: push, full-stack push and empty pop register their result in the cycle after acceptance;
//   a pop leaving one or more levels first reads the stack memory, then registers the output.
// Throughput: one push per cycle while the output is not stalled; a pop that reads the level
//   below holds off new input while the single memory read port returns that level.
// Reset: synchronous, active low; clears depth, control and output valid and sets the
//   display size to 640x480. The stack memory is not cleared.
module scissor_stack_intersect_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssi_req_if.sink           i_req,
    ssi_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ssi_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [DW-1:0]   r_depth, n_depth;
    t_rect           r_top, n_top;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;
    logic [15:0]     r_disp_w, r_disp_h;
    t_rect           mem [STACK_DEPTH];
    t_rect           r_rd_data;

    logic            in_ready;
    logic            accept;
    logic            full;
    logic            mem_we;
    logic            rd_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            cfg_we;
    t_rect           base;
    t_rect           folded;
    t_axis           fx, fy;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_DISP_H) ? {16'd0, r_disp_h} : {16'd0, r_disp_w};

    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept   = i_req.valid && in_ready;
    assign full     = (r_depth == DW'(STACK_DEPTH));
    assign wr_addr  = r_depth[AW-1:0];
    assign rd_addr  = AW'(r_depth - DW'(2));

    always_comb begin
        if (r_depth == '0) begin
            base = '{x: 15'd0, y: 15'd0, w: r_disp_w, h: r_disp_h};
        end else begin
            base = r_top;
        end
        fx = fold_axis(base.x, base.w, i_req.rect_x, i_req.rect_w);
        fy = fold_axis(base.y, base.h, i_req.rect_y, i_req.rect_h);
        folded = '{x: fx.pos, y: fy.pos, w: fx.size, h: fy.size};
    end

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_top       = r_top;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_PUSH) begin
                        n_out_valid = 1'b1;
                        if (full) begin
                            n_out = '{clip_enable: 1'b1, rect: r_top, error_code: ERR_FULL};
                        end else begin
                            mem_we  = 1'b1;
                            n_top   = folded;
                            n_depth = r_depth + DW'(1);
                            n_out   = '{clip_enable: 1'b1, rect: folded, error_code: ERR_OK};
                        end
                    end else if (r_depth == '0) begin
                        n_out_valid = 1'b1;
                        n_out = '{clip_enable: 1'b0, rect: '0, error_code: ERR_EMPTY};
                    end else if (r_depth == DW'(1)) begin
                        n_out_valid = 1'b1;
                        n_depth     = '0;
                        n_out = '{clip_enable: 1'b0, rect: '0, error_code: ERR_OK};
                    end else begin
                        n_depth = r_depth - DW'(1);
                        rd_en   = 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                n_top       = r_rd_data;
                n_out       = '{clip_enable: 1'b1, rect: r_rd_data, error_code: ERR_OK};
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= folded;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_disp_w    <= DISP_W_RESET;
            r_disp_h    <= DISP_H_RESET;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (cfg_we && paddr[2] == REG_DISP_W) begin
                r_disp_w <= pwdata[15:0];
            end
            if (cfg_we && paddr[2] == REG_DISP_H) begin
                r_disp_h <= pwdata[15:0];
            end
        end
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.clip_enable = r_out.clip_enable;
    assign o_rsp.clip_x      = r_out.rect.x;
    assign o_rsp.clip_y      = r_out.rect.y;
    assign o_rsp.clip_w      = r_out.rect.w;
    assign o_rsp.clip_h      = r_out.rect.h;
    assign o_rsp.error_code  = r_out.error_code;

endmodule

[design/ssi_checker.sv]
module ssi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_req_type,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_clip_enable,
    input logic [14:0] i_clip_x,
    input logic [14:0] i_clip_y,
    input logic [15:0] i_clip_w,
    input logic [15:0] i_clip_h,
    input logic [1:0]  i_error_code
);
    import ssi_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_clip_enable)
            && $stable(i_clip_x) && $stable(i_clip_y) && $stable(i_clip_w)
            && $stable(i_clip_h) && $stable(i_error_code))
        else $error("result changed while stalled");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_clip_enable |-> i_clip_x == 15'd0 && i_clip_y == 15'd0
            && i_clip_w == 16'd0 && i_clip_h == 16'd0)
        else $error("disabled clip with nonzero rectangle");

    a_full_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_error_code == ERR_FULL |-> i_clip_enable)
        else $error("full-stack error without active clip");

    a_empty_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_error_code == ERR_EMPTY |-> !i_clip_enable)
        else $error("empty-stack error with active clip");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_type == REQ_PUSH |=> i_rsp_valid)
        else $error("push transaction without result on next cycle");

endmodule

bind scissor_stack_intersect_unit ssi_checker u_ssi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_type    (i_req.req_type),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_clip_enable (o_rsp.clip_enable),
    .i_clip_x      (o_rsp.clip_x),
    .i_clip_y      (o_rsp.clip_y),
    .i_clip_w      (o_rsp.clip_w),
    .i_clip_h      (o_rsp.clip_h),
    .i_error_code  (o_rsp.error_code)
);

[verif/scissor_stack_intersect_unit_test.sv]
`timescale 1ns / 100ps

module scissor_stack_intersect_unit_test;
    import ssi_pkg::*;

    localparam int STACK_LEVELS = 16;

    typedef struct {
        logic               op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
    } t_cmd;

    class clip_tracker;
        int      disp_w;
        int      disp_h;
        int      depth;
        int      errors;
        t_rect   levels[STACK_LEVELS];
        t_result clip_q[$];

        function new();
            disp_w = DISP_W_RESET;
            disp_h = DISP_H_RESET;
            depth  = 0;
            errors = 0;
        endfunction

        function void fold(inout int pos, inout int size, input int ipos, input int isize);
            int lo;
            int hi_t;
            int hi_i;
            int hi;
            lo   = (ipos > pos) ? ipos : pos;
            hi_t = pos + size;
            hi_i = ipos + isize;
            hi   = (hi_i < hi_t) ? hi_i : hi_t;
            pos  = lo;
            size = (hi > lo) ? hi - lo : 0;
        endfunction

        function void note_request(t_cmd c);
            t_result r;
            int      x;
            int      y;
            int      w;
            int      h;
            int      ix;
            int      iy;
            r  = '0;
            ix = c.x;
            iy = c.y;
            if (c.op == REQ_PUSH) begin
                r.clip_enable = 1'b1;
                if (depth >= STACK_LEVELS) begin
                    r.rect       = levels[STACK_LEVELS-1];
                    r.error_code = ERR_FULL;
                end else begin
                    if (depth == 0) begin
                        x = 0;
                        y = 0;
                        w = disp_w;
                        h = disp_h;
                    end else begin
                        x = levels[depth-1].x;
                        y = levels[depth-1].y;
                        w = levels[depth-1].w;
                        h = levels[depth-1].h;
                    end
                    fold(x, w, ix, int'(c.w));
                    fold(y, h, iy, int'(c.h));
                    levels[depth].x = x[14:0];
                    levels[depth].y = y[14:0];
                    levels[depth].w = w[15:0];
                    levels[depth].h = h[15:0];
                    r.rect       = levels[depth];
                    r.error_code = ERR_OK;
                    depth++;
                end
            end else if (depth == 0) begin
                r.error_code = ERR_EMPTY;
            end else begin
                depth--;
                r.error_code = ERR_OK;
                if (depth > 0) begin
                    r.clip_enable = 1'b1;
                    r.rect        = levels[depth-1];
                end
            end
            clip_q.insert(clip_q.size(), r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (clip_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            exp_r = clip_q.pop_front();
            compare_field("clip_enable", exp_r.clip_enable, got.clip_enable);
            compare_field("clip_x", exp_r.rect.x, got.rect.x);
            compare_field("clip_y", exp_r.rect.y, got.rect.y);
            compare_field("clip_w", exp_r.rect.w, got.rect.w);
            compare_field("clip_h", exp_r.rect.h, got.rect.h);
            compare_field("error_code", exp_r.error_code, got.error_code);
        endfunction

        function int pending();
            return clip_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ssi_req_if req();
    ssi_rsp_if rsp();

    clip_tracker sb = new();

    scissor_stack_intersect_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready) begin
            sb.note_request('{req.req_type, req.rect_x, req.rect_y, req.rect_w, req.rect_h});
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got.clip_enable = rsp.clip_enable;
            got.rect.x      = rsp.clip_x;
            got.rect.y      = rsp.clip_y;
            got.rect.w      = rsp.clip_w;
            got.rect.h      = rsp.clip_h;
            got.error_code  = rsp.error_code;
            sb.check_result(got);
        end
    end

    // receiver back-pressure: a randomly chosen mode drives ready for a random span
    initial begin
        int mode;
        int span;
        rsp.ready <= 1'b0;
        mode = 0;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 100);
            end
            span--;
            case (mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= $urandom_range(0, 1);
                2: rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= span[0];
            endcase
        end
    end

    initial begin
        #500000;
        $display("scissor_stack_intersect_unit_test NOT OK");
        $finish;
    end

    task automatic send_cmd(t_cmd c);
        req.valid    <= 1'b1;
        req.req_type <= c.op;
        req.rect_x   <= c.x;
        req.rect_y   <= c.y;
        req.rect_w   <= c.w;
        req.rect_h   <= c.h;
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            req.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic reg_sel, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_DISP_W)
            sb.disp_w = value;
        else
            sb.disp_h = value;
        @(posedge i_clk);
    endtask

    function automatic t_cmd mk_cmd(logic op, int x, int y, int w, int h);
        t_cmd c;
        c.op = op;
        c.x  = x[15:0];
        c.y  = y[15:0];
        c.w  = w[15:0];
        c.h  = h[15:0];
        return c;
    endfunction

    function automatic int near_pos(int span);
        int v;
        if ($urandom_range(0, 9) == 0)
            return $signed(16'($urandom));
        v = $urandom_range(0, span + 600) - 300;
        return (v > 32767) ? 32767 : v;
    endfunction

    function automatic int near_size(int span);
        int v;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 65535);
        v = $urandom_range(0, span + 400);
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic t_cmd random_cmd(bit favor_push);
        logic op;
        op = ($urandom_range(0, 99) < (favor_push ? 80 : 20)) ? REQ_PUSH : REQ_POP;
        return mk_cmd(op, near_pos(sb.disp_w), near_pos(sb.disp_h),
                      near_size(sb.disp_w), near_size(sb.disp_h));
    endfunction

    task automatic run_random(int n);
        int burst;
        int walk;
        bit up;
        burst = $urandom_range(1, 12);
        walk  = $urandom_range(8, 40);
        up    = 1'b1;
        repeat (n) begin
            if (walk == 0) begin
                up   = ~up;
                walk = $urandom_range(8, 40);
            end
            walk--;
            send_cmd(random_cmd(up));
            burst--;
            if (burst == 0) begin
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                burst = $urandom_range(1, 12);
            end
        end
        drain();
    endtask

    initial begin
        logic [15:0] cfg_w[5];
        logic [15:0] cfg_h[5];
        i_rst_n      <= 1'b0;
        req.valid    <= 1'b0;
        req.req_type <= REQ_PUSH;
        req.rect_x   <= '0;
        req.rect_y   <= '0;
        req.rect_w   <= '0;
        req.rect_h   <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pop, extreme edges, negative right/top edge, fill, full push, pops
        send_cmd(mk_cmd(REQ_POP, 0, 0, 0, 0));
        send_cmd(mk_cmd(REQ_PUSH, -32768, -32768, 65535, 65535));
        send_cmd(mk_cmd(REQ_PUSH, -100, -50, 740, 530));
        send_cmd(mk_cmd(REQ_PUSH, 10, 20, 600, 400));
        send_cmd(mk_cmd(REQ_PUSH, -32768, -32768, 32800, 32800));
        send_cmd(mk_cmd(REQ_PUSH, 5, 5, 65535, 65535));
        send_cmd(mk_cmd(REQ_PUSH, -100, -100, 50, 50));
        send_cmd(mk_cmd(REQ_PUSH, 32767, 32767, 65535, 0));
        repeat (9) send_cmd(random_cmd(1'b1));
        send_cmd(mk_cmd(REQ_PUSH, 1, 1, 1, 1));
        repeat (5) send_cmd(mk_cmd(REQ_POP, 32767, -1, 65535, 65535));
        drain();

        run_random(90);

        cfg_w = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(2, 4000)), 16'd1920};
        cfg_h = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(2, 4000)), 16'd1080};
        for (int i = 0; i < 5; i++) begin
            reg_write(REG_DISP_W, cfg_w[i]);
            reg_write(REG_DISP_H, cfg_h[i]);
            run_random(90);
        end

        if (sb.errors == 0)
            $display("scissor_stack_intersect_unit_test OK");
        else
            $display("scissor_stack_intersect_unit_test NOT OK");
        $finish;
    end

endmodule
